@@ src/ship_pkg.sv @@
// shared types, constants and helpers for the signature rrip replacement block
`default_nettype none
package ship_pkg;

	localparam int NUM_SETS = 2048;
	localparam int NUM_WAYS = 16;
	localparam int SIG_BITS = 14;

	localparam int SET_AW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_W     = $clog2(NUM_WAYS);
	localparam int SIG_COUNT = 1 << SIG_BITS;

	localparam logic [1:0] RRPV_TOP    = 2'd3;
	localparam logic [1:0] CTR_TOP     = 2'd3;
	localparam logic [1:0] CTR_START   = 2'd2;
	localparam logic [1:0] SHORT_RESET = 2'd2;
	localparam logic [1:0] LONG_RESET  = 2'd3;

	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INSERT_SHORT = 2'd0,
		REG_INSERT_LONG  = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [10:0] set_index;
		logic [3:0]  hit_way;
		logic        hit;
		logic [13:0] pc_bits;
		logic [13:0] page_bits;
	} access_t;

	typedef struct packed {
		logic [3:0] chosen_way;
		logic       was_fill;
		logic       dead_eviction;
		logic       predicted_reuse;
	} result_t;

	typedef struct packed {
		logic [1:0]          rrpv;
		logic                reused;
		logic [SIG_BITS-1:0] sig;
	} line_t;

	typedef line_t [NUM_WAYS-1:0] row_t;
	localparam int ROW_W = $bits(row_t);

	localparam line_t LINE_RESET = '{rrpv: RRPV_TOP, reused: 1'b0, sig: '0};

	typedef struct packed {
		logic [WAY_W-1:0]          victim;
		logic [NUM_WAYS-1:0][1:0]  rrpv;
	} age_t;

	// set index folded into the configured number of sets
	function automatic logic [SET_AW-1:0] wrap_set(input logic [10:0] s);
		int r;
		r = int'(s);
		if (NUM_SETS == 1) begin
			r = 0;
		end else if (NUM_SETS < 2048) begin
			for (int k = 10; k >= 0; k--) begin
				if ((NUM_SETS << k) <= 2047 && r >= (NUM_SETS << k)) begin
					r = r - (NUM_SETS << k);
				end
			end
		end
		return SET_AW'(r);
	endfunction

	function automatic logic [SIG_BITS-1:0] make_sig(input logic [13:0] pc,
		input logic [13:0] page);
		logic [13:0] x;
		x = pc ^ page;
		return SIG_BITS'(x);
	endfunction

endpackage
`default_nettype wire

@@ src/ship_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none
module ship_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ src/ship_age.sv @@
// set ageing and victim pick over one row of re-reference values
`default_nettype none
module ship_age (
	input  ship_pkg::row_t row,
	output ship_pkg::age_t res
);
	import ship_pkg::*;

	always_comb begin
		logic       any3;
		logic       any2;
		logic       any1;
		logic [1:0] add;
		logic       found;
		any3 = 1'b0;
		any2 = 1'b0;
		any1 = 1'b0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (row[w].rrpv == 2'd3) any3 = 1'b1;
			if (row[w].rrpv == 2'd2) any2 = 1'b1;
			if (row[w].rrpv == 2'd1) any1 = 1'b1;
		end
		// distance of the oldest line from the top value
		add = any3 ? 2'd0 : (any2 ? 2'd1 : (any1 ? 2'd2 : 2'd3));
		for (int w = 0; w < NUM_WAYS; w++) begin
			res.rrpv[w] = row[w].rrpv + add;
		end
		// lowest way at the top value
		found      = 1'b0;
		res.victim = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (!found && res.rrpv[w] == RRPV_TOP) begin
				res.victim = WAY_W'(w);
				found      = 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ src/signature_rrip_replacement.sv @@
// top level: signature based rrip replacement with set and counter memories
// sequence: a hit to an already reused line or to an out of range way ends in the row state,
//   a first reuse adds a counter state, a miss evicting a reused line goes on to the fill state,
//   a dead eviction passes through both; the result register stalls while res_stall holds it;
//   one request at a time, the next waits for the set-row and counter table read-modify-write
// reset: a clearing pass over max(NUM_SETS, 2^SIG_BITS) entries (16384) runs
//   first, requests are stalled meanwhile; configuration writes are taken always
`default_nettype none
module signature_rrip_replacement (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       acc_valid,
	output logic                       acc_stall,
	input  ship_pkg::access_t          acc,
	output logic                       res_valid,
	input  logic                       res_stall,
	output ship_pkg::result_t          res,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [ship_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [1:0]                 cfg_data
);
	import ship_pkg::*;

	localparam int CLR_N = (NUM_SETS > SIG_COUNT) ? NUM_SETS : SIG_COUNT;
	localparam int CLR_W = $clog2(CLR_N) + 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROW,
		ST_CTR_A,
		ST_CTR_B
	} state_t;

	state_t state_q;
	logic [CLR_W-1:0] clr_q;

	// request held for the whole sequence
	access_t             acc_q;
	logic [SET_AW-1:0]   set_q;
	logic [SIG_BITS-1:0] sig_new_q;
	logic [SIG_BITS-1:0] sig_a_q;
	row_t                row_q;
	logic [WAY_W-1:0]    victim_q;
	logic                dead_q;
	logic [1:0]          dec_q;
	logic                fwd_q;

	logic       res_valid_q;
	result_t    res_q;
	logic [1:0] short_q;
	logic [1:0] long_q;

	// memory ports
	logic                row_we;
	logic [SET_AW-1:0]   row_waddr;
	row_t                row_wdata;
	logic                row_re;
	logic [SET_AW-1:0]   row_raddr;
	row_t                row_rd;
	logic                ctr_we;
	logic [SIG_BITS-1:0] ctr_waddr;
	logic [1:0]          ctr_wdata;
	logic                ctr_re;
	logic [SIG_BITS-1:0] ctr_raddr;
	logic [1:0]          ctr_rd;

	logic             acc_fire;
	logic             out_free;
	logic             finish;
	logic             done;
	logic             way_ok;
	logic [WAY_W-1:0] way_idx;
	line_t            hline;
	line_t            vline;
	row_t             hit_row;
	row_t             miss_row;
	age_t             age_res;
	logic [1:0]       ctr_inc;
	logic [1:0]       ctr_dec;
	logic             reuse_b;
	result_t          res_next;

	assign acc_stall = (state_q != ST_IDLE);
	assign acc_fire  = acc_valid && !acc_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign cfg_ready = 1'b1;

	// result register is free when empty or being taken this cycle
	assign out_free = !res_valid_q || !res_stall;

	ship_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (row_wdata),
		.re    (row_re),
		.raddr (row_raddr),
		.rdata (row_rd)
	);

	ship_ram #(.WIDTH(2), .DEPTH(SIG_COUNT)) u_ctr_ram (
		.clk   (clk),
		.we    (ctr_we),
		.waddr (ctr_waddr),
		.wdata (ctr_wdata),
		.re    (ctr_re),
		.raddr (ctr_raddr),
		.rdata (ctr_rd)
	);

	ship_age u_age (
		.row (row_rd),
		.res (age_res)
	);

	// hit path: the way from the request, only meaningful when in range
	assign way_idx = WAY_W'(acc_q.hit_way);
	assign way_ok  = int'(acc_q.hit_way) < NUM_WAYS;
	assign hline   = row_rd[way_idx];
	assign vline   = row_rd[age_res.victim];

	// counter saturation
	assign ctr_inc = (ctr_rd == CTR_TOP) ? ctr_rd : ctr_rd + 2'd1;
	assign ctr_dec = (ctr_rd == 2'd0) ? ctr_rd : ctr_rd - 2'd1;

	// new signature counter, forwarded when it is the one just decremented
	assign reuse_b = fwd_q ? (dec_q != 2'd0) : (ctr_rd != 2'd0);

	always_comb begin
		hit_row = row_rd;
		hit_row[way_idx].rrpv   = 2'd0;
		hit_row[way_idx].reused = 1'b1;
		miss_row = row_rd;
		for (int w = 0; w < NUM_WAYS; w++) begin
			miss_row[w].rrpv = age_res.rrpv[w];
		end
		miss_row[age_res.victim].sig    = sig_new_q;
		miss_row[age_res.victim].reused = 1'b0;
	end

	// memory control and result selection per state
	always_comb begin
		row_we    = 1'b0;
		row_waddr = set_q;
		row_wdata = row_q;
		row_re    = 1'b0;
		row_raddr = wrap_set(acc.set_index);
		ctr_we    = 1'b0;
		ctr_waddr = sig_a_q;
		ctr_wdata = ctr_dec;
		ctr_re    = 1'b0;
		ctr_raddr = sig_new_q;
		finish    = 1'b0;
		res_next  = '{chosen_way: acc_q.hit_way, was_fill: 1'b0,
			dead_eviction: 1'b0, predicted_reuse: 1'b0};
		case (state_q)
			ST_CLEAR: begin
				row_we    = clr_q < CLR_W'(NUM_SETS);
				row_waddr = SET_AW'(clr_q);
				row_wdata = {NUM_WAYS{LINE_RESET}};
				ctr_we    = clr_q < CLR_W'(SIG_COUNT);
				ctr_waddr = SIG_BITS'(clr_q);
				ctr_wdata = CTR_START;
			end
			ST_IDLE: begin
				row_re = acc_fire;
			end
			ST_ROW: begin
				if (acc_q.hit) begin
					if (!way_ok) begin
						// way out of range: nothing changes
						finish = 1'b1;
					end else if (hline.reused) begin
						finish    = 1'b1;
						row_we    = out_free;
						row_wdata = hit_row;
					end else begin
						ctr_re    = 1'b1;
						ctr_raddr = hline.sig;
					end
				end else begin
					ctr_re    = 1'b1;
					ctr_raddr = vline.reused ? sig_new_q : vline.sig;
				end
			end
			ST_CTR_A: begin
				if (acc_q.hit) begin
					finish    = 1'b1;
					ctr_we    = out_free;
					ctr_wdata = ctr_inc;
					row_we    = out_free;
					row_wdata = row_q;
				end else begin
					// dead victim lowers its counter, then the new signature is read
					ctr_we    = 1'b1;
					ctr_wdata = ctr_dec;
					ctr_re    = 1'b1;
					ctr_raddr = sig_new_q;
				end
			end
			ST_CTR_B: begin
				finish    = 1'b1;
				row_we    = out_free;
				row_wdata = row_q;
				row_wdata[victim_q].rrpv = reuse_b ? short_q : long_q;
				res_next  = '{chosen_way: 4'(victim_q), was_fill: 1'b1,
					dead_eviction: dead_q, predicted_reuse: reuse_b};
			end
			default: begin
			end
		endcase
	end

	assign done = finish && out_free;

	// sequencer, result register and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			short_q     <= SHORT_RESET;
			long_q      <= LONG_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_INSERT_SHORT: short_q <= cfg_data;
					REG_INSERT_LONG:  long_q  <= cfg_data;
					default: begin
					end
				endcase
			end

			if (done) begin
				res_valid_q <= 1'b1;
				res_q       <= res_next;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CLR_W'(1);
					if (clr_q == CLR_W'(CLR_N - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc_fire) begin
						state_q <= ST_ROW;
					end
				end
				ST_ROW: begin
					if (done) begin
						state_q <= ST_IDLE;
					end else if (acc_q.hit) begin
						if (!finish) begin
							state_q <= ST_CTR_A;
						end
					end else if (vline.reused) begin
						state_q <= ST_CTR_B;
					end else begin
						state_q <= ST_CTR_A;
					end
				end
				ST_CTR_A: begin
					if (done) begin
						state_q <= ST_IDLE;
					end else if (!acc_q.hit) begin
						state_q <= ST_CTR_B;
					end
				end
				ST_CTR_B: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request payload and intermediate row, no reset needed
	always_ff @(posedge clk) begin
		if (acc_fire) begin
			acc_q     <= acc;
			set_q     <= wrap_set(acc.set_index);
			sig_new_q <= make_sig(acc.pc_bits, acc.page_bits);
		end
		if (state_q == ST_ROW) begin
			if (acc_q.hit) begin
				row_q   <= hit_row;
				sig_a_q <= hline.sig;
			end else begin
				row_q    <= miss_row;
				victim_q <= age_res.victim;
				dead_q   <= !vline.reused;
				sig_a_q  <= vline.sig;
				fwd_q    <= 1'b0;
			end
		end
		if (state_q == ST_CTR_A && !acc_q.hit) begin
			dec_q <= ctr_dec;
			fwd_q <= (sig_new_q == sig_a_q);
		end
	end

endmodule
`default_nettype wire

@@ src/ship_checker.sv @@
// port-level checks for the signature rrip replacement block, with its bind
`default_nettype none
module ship_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           acc_valid,
	input logic                           acc_stall,
	input ship_pkg::access_t              acc,
	input logic                           res_valid,
	input logic                           res_stall,
	input ship_pkg::result_t              res,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [ship_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [1:0]                     cfg_data
);

	// a waiting result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed");

	// one request in flight: stall follows every accepted request
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		acc_valid && !acc_stall |=> acc_stall)
		else $error("request accepted while another in flight");

	// no fill means no eviction and no prediction
	a_hit_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.was_fill |-> !res.dead_eviction && !res.predicted_reuse)
		else $error("hit result carries fill fields");

	// configuration writes are always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind signature_rrip_replacement ship_checker u_ship_checker (.*);
`default_nettype wire

@@ verif/signature_rrip_replacement_test.sv @@
// self-checking testbench for the signature rrip replacement block
`default_nettype none
module signature_rrip_replacement_test;
	import ship_pkg::*;

	localparam int LINES = NUM_SETS * NUM_WAYS;
	// indexes past the two insertion registers, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic acc_valid = 1'b0;
	logic acc_stall;
	access_t acc = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	result_t res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_INSERT_SHORT;
	logic [1:0] cfg_data = '0;

	signature_rrip_replacement i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc_valid (acc_valid),
		.acc_stall (acc_stall),
		.acc       (acc),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mirror of the replacement state, cleared the way the block clears its memories
	logic [1:0]          rrpv_mirror   [LINES];
	logic [SIG_BITS-1:0] sig_mirror    [LINES];
	logic                reused_mirror [LINES];
	logic [1:0]          ctr_mirror    [SIG_COUNT];
	logic [1:0]          short_insert = SHORT_RESET;
	logic [1:0]          long_insert  = LONG_RESET;

	// results still owed by the block, oldest first
	result_t awaited_results[$];
	int unsigned mismatch_count = 0;
	int unsigned result_count = 0;
	int unsigned burst_left = 1;

	// hot sets and signatures so that lines get reused, aged and evicted
	logic [10:0] hot_sets [6];
	logic [13:0] hot_sigs [5];

	task automatic note_mismatch(input string msg);
		if (mismatch_count < 100) begin
			$display("mismatch at result %0d: %s", result_count, msg);
		end
		mismatch_count++;
	endtask

	// one access through the replacement policy, updating the mirror
	function automatic result_t predict_replacement(input access_t a);
		int unsigned base, ln, top, lift, victim, v;
		bit found, dead, reuse;
		logic [SIG_BITS-1:0] fill_sig;
		result_t r;
		// set index folds into the number of sets
		base = (int'(a.set_index) % NUM_SETS) * NUM_WAYS;
		r = '0;
		r.chosen_way = a.hit_way;
		if (a.hit) begin
			// an out of range way leaves everything as it was
			if (int'(a.hit_way) < NUM_WAYS) begin
				ln = base + int'(a.hit_way);
				rrpv_mirror[ln] = '0;
				if (!reused_mirror[ln]) begin
					reused_mirror[ln] = 1'b1;
					if (ctr_mirror[sig_mirror[ln]] < CTR_TOP) begin
						ctr_mirror[sig_mirror[ln]] = ctr_mirror[sig_mirror[ln]] + 2'd1;
					end
				end
			end
			return r;
		end
		// age the whole set so its largest value reaches the top, first top way loses
		top = 0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (32'(rrpv_mirror[base + w]) > top) begin
				top = 32'(rrpv_mirror[base + w]);
			end
		end
		lift = 32'(RRPV_TOP) - top;
		victim = 0;
		found = 1'b0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			v = 32'(rrpv_mirror[base + w]) + lift;
			rrpv_mirror[base + w] = v[1:0];
			if (!found && v == 32'(RRPV_TOP)) begin
				victim = w;
				found = 1'b1;
			end
		end
		ln = base + victim;
		dead = !reused_mirror[ln];
		// the victim's counter drops before the fill reads its own, may be one entry
		if (dead && ctr_mirror[sig_mirror[ln]] > 2'd0) begin
			ctr_mirror[sig_mirror[ln]] = ctr_mirror[sig_mirror[ln]] - 2'd1;
		end
		fill_sig = SIG_BITS'(a.pc_bits ^ a.page_bits);
		reuse = ctr_mirror[fill_sig] > 2'd0;
		sig_mirror[ln] = fill_sig;
		reused_mirror[ln] = 1'b0;
		rrpv_mirror[ln] = reuse ? short_insert : long_insert;
		r.chosen_way = 4'(victim);
		r.was_fill = 1'b1;
		r.dead_eviction = dead;
		r.predicted_reuse = reuse;
		return r;
	endfunction

	function automatic access_t pack_access(input logic [10:0] set_index,
		input logic [3:0] way, input logic hit, input logic [13:0] pc,
		input logic [13:0] page);
		access_t a;
		a.set_index = set_index;
		a.hit_way = way;
		a.hit = hit;
		a.pc_bits = pc;
		a.page_bits = page;
		return a;
	endfunction

	// hand one request over, then keep going in the burst or back off for a gap
	task automatic send_access(input access_t a);
		acc <= a;
		acc_valid <= 1'b1;
		do @(posedge clk); while (acc_stall !== 1'b0);
		awaited_results.push_back(predict_replacement(a));
		burst_left--;
		if (burst_left == 0) begin
			acc_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
	endtask

	// stop requesting and let the block empty out before touching its registers
	task automatic wait_until_idle();
		acc_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_insertion_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_INSERT_SHORT: short_insert = val;
			REG_INSERT_LONG: long_insert = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// mostly hot sets and signatures, the rest fully random noise
	task automatic run_random_traffic(input int unsigned count);
		access_t a;
		for (int k = 0; k < 6; k++) begin
			hot_sets[k] = 11'($urandom_range(0, 2047));
		end
		if ($urandom_range(0, 1) == 0) begin
			hot_sets[0] = '0;
			hot_sets[1] = '1;
		end
		for (int k = 0; k < 5; k++) begin
			hot_sigs[k] = 14'($urandom_range(0, 16383));
		end
		for (int unsigned n = 0; n < count; n++) begin
			if ($urandom_range(0, 4) == 0) begin
				a = pack_access(11'($urandom_range(0, 2047)), 4'($urandom_range(0, 15)),
					1'($urandom_range(0, 1)), 14'($urandom_range(0, 16383)),
					14'($urandom_range(0, 16383)));
			end else begin
				a.set_index = hot_sets[$urandom_range(0, 5)];
				a.hit_way = 4'($urandom_range(0, 15));
				a.hit = 1'($urandom_range(0, 1));
				a.pc_bits = 14'($urandom_range(0, 16383));
				a.page_bits = a.pc_bits ^ hot_sigs[$urandom_range(0, 4)];
			end
			send_access(a);
		end
	endtask

	// field extremes, hits and misses, victim and fill sharing one signature
	task automatic test_edge_cases();
		// fresh sets all carry signature zero, so these fills share the victim's counter
		send_access(pack_access(11'd0, 4'd0, 1'b0, 14'h0000, 14'h0000));
		send_access(pack_access(11'd2047, 4'd0, 1'b0, 14'h3fff, 14'h3fff));
		send_access(pack_access(11'd1, 4'd0, 1'b0, 14'h1555, 14'h1555));
		// counter for signature zero is now empty, fill goes in long
		send_access(pack_access(11'd2, 4'd9, 1'b0, 14'h2aaa, 14'h2aaa));
		// first reuse then repeat hit on the same line
		send_access(pack_access(11'd0, 4'd0, 1'b1, 14'h3fff, 14'h3fff));
		send_access(pack_access(11'd0, 4'd0, 1'b1, 14'h0000, 14'h0000));
		// hit on a line never filled, top way and top set
		send_access(pack_access(11'd2047, 4'd15, 1'b1, 14'h3fff, 14'h0000));
		send_access(pack_access(11'd2047, 4'd15, 1'b1, 14'h0000, 14'h3fff));
		// fresh signatures at the field extremes
		send_access(pack_access(11'd0, 4'd15, 1'b0, 14'h3fff, 14'h0000));
		send_access(pack_access(11'd2047, 4'd0, 1'b0, 14'h0000, 14'h3fff));
		// hit the lowest four ways of one set, then miss in the same set
		for (int w = 0; w < 4; w++) begin
			send_access(pack_access(11'd3, 4'(w), 1'b1, 14'h0123, 14'h0456));
		end
		send_access(pack_access(11'd3, 4'd0, 1'b0, 14'h0123, 14'h0456));
		// a hit on set zero way one, then two misses in set zero
		send_access(pack_access(11'd0, 4'd1, 1'b1, 14'h1111, 14'h2222));
		send_access(pack_access(11'd0, 4'd0, 1'b0, 14'h1111, 14'h2222));
		send_access(pack_access(11'd0, 4'd0, 1'b0, 14'h3333, 14'h0c0c));
		wait_until_idle();
	endtask

	// writes to indexes beyond the two registers must not disturb the insertion values
	task automatic test_spare_register_writes();
		write_insertion_reg(REG_SPARE_A, 2'd0);
		write_insertion_reg(REG_SPARE_B, 2'd1);
		run_random_traffic(60);
		wait_until_idle();
	endtask

	// random traffic under a spread of insertion settings, extremes included
	task automatic test_insertion_settings();
		logic [1:0] short_set [6];
		logic [1:0] long_set [6];
		short_set = '{2'd0, 2'd3, 2'd0, 2'd3, 2'd1, 2'd2};
		long_set  = '{2'd0, 2'd3, 2'd3, 2'd0, 2'd2, 2'd1};
		for (int p = 0; p < 6; p++) begin
			write_insertion_reg(REG_INSERT_SHORT, short_set[p]);
			write_insertion_reg(REG_INSERT_LONG, long_set[p]);
			run_random_traffic(280);
			wait_until_idle();
		end
	endtask

	// result side: stall pattern cycling through free flow, light, heavy and regular
	logic [15:0] rx_cycle = '0;
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 16'd1;
		case (rx_cycle[10:9])
			2'd0: res_stall <= 1'b0;
			2'd1: res_stall <= ($urandom_range(0, 3) == 0);
			2'd2: res_stall <= ($urandom_range(0, 3) != 0);
			default: res_stall <= rx_cycle[2];
		endcase
	end

	// compare every accepted result with the oldest awaited one
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (awaited_results.size() == 0) begin
				note_mismatch("result arrived with none awaited");
			end else begin
				want = awaited_results.pop_front();
				if (res.chosen_way !== want.chosen_way) begin
					note_mismatch($sformatf("chosen_way %0d, expected %0d",
						res.chosen_way, want.chosen_way));
				end
				if (res.was_fill !== want.was_fill) begin
					note_mismatch($sformatf("was_fill %0b, expected %0b",
						res.was_fill, want.was_fill));
				end
				if (res.dead_eviction !== want.dead_eviction) begin
					note_mismatch($sformatf("dead_eviction %0b, expected %0b",
						res.dead_eviction, want.dead_eviction));
				end
				if (res.predicted_reuse !== want.predicted_reuse) begin
					note_mismatch($sformatf("predicted_reuse %0b, expected %0b",
						res.predicted_reuse, want.predicted_reuse));
				end
			end
			result_count++;
		end
	end

	initial begin
		for (int i = 0; i < LINES; i++) begin
			rrpv_mirror[i] = RRPV_TOP;
			sig_mirror[i] = '0;
			reused_mirror[i] = 1'b0;
		end
		for (int i = 0; i < SIG_COUNT; i++) begin
			ctr_mirror[i] = CTR_START;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// the block clears its memories first, requests wait on acc_stall meanwhile
		test_edge_cases();
		test_spare_register_writes();
		test_insertion_settings();
		wait_until_idle();
		if (mismatch_count == 0) begin
			$display("signature_rrip_replacement regression: pass");
		end else begin
			$display("signature_rrip_replacement regression: fail");
		end
		$finish;
	end

	// generous ceiling: clearing pass plus every request at its slowest
	initial begin
		#6000000;
		$display("signature_rrip_replacement regression: fail");
		$finish;
	end

endmodule
`default_nettype wire
